/* rtl/sobel_edge_magnitude_core_assert.svh */
// Assertion helpers shared by the sobel core modules.
`ifndef SOBEL_EDGE_MAGNITUDE_CORE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_CORE_ASSERT_SVH

// Same-cycle implication.
`define SEM_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SEM_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sem_pkg.sv */
package sem_pkg;

  localparam int PIX_W    = 8;
  localparam int WCFG_W   = 11;
  localparam int HCFG_W   = 13;
  localparam int CFG_W    = 13;
  localparam int CNT_W    = 23;
  localparam int ROW_W    = 13;
  localparam int ACC_W    = 12;
  localparam int SQ_W     = 21;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_t;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [WCFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [HCFG_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic [SQ_W-1:0]  SQ_CLAMP = 21'd65025;
  localparam logic [PIX_W-1:0] EDGE_MAX = 8'd255;

  // Which neighbors of the center pixel lie inside the image, and whether it is the frame's last pixel.
  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic frame_end;
  } job_flags_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_SQUARE,
    BK_ROOT,
    BK_ROUND,
    BK_DONE
  } back_state_t;

endpackage

/* rtl/sem_ram.sv */
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sem_front.sv */
`include "sobel_edge_magnitude_core_assert.svh"

module sem_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int AW        = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [0:0]                  cfg_index,
  input  logic [sem_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        operation,
  input  logic [sem_pkg::PIX_W-1:0]   red_in,
  input  logic [sem_pkg::PIX_W-1:0]   green_in,
  input  logic [sem_pkg::PIX_W-1:0]   blue_in,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [3*sem_pkg::PIX_W-1:0] wr_data,
  output logic                        push,
  output logic [AW-1:0]               push_ptr,
  output sem_pkg::job_flags_t         push_flags,
  input  logic                        q_full,
  output logic [sem_pkg::WCFG_W-1:0]  width
);

  localparam logic [sem_pkg::WCFG_W-1:0] MAX_W =
    (MAX_WIDTH > 2047) ? 11'd2047 : 11'(MAX_WIDTH);

  function automatic logic [sem_pkg::WCFG_W-1:0] eff_w(input logic [sem_pkg::WCFG_W-1:0] v);
    logic [sem_pkg::WCFG_W-1:0] r;
    r = v;
    if (v == '0) r = 11'd1;
    else if (v > MAX_W) r = MAX_W;
    return r;
  endfunction

  function automatic logic [sem_pkg::HCFG_W-1:0] eff_h(input logic [sem_pkg::HCFG_W-1:0] v);
    return (v == '0) ? 13'd1 : v;
  endfunction

  logic [sem_pkg::WCFG_W-1:0] w_eff;
  logic [sem_pkg::HCFG_W-1:0] h_eff;
  logic [sem_pkg::CNT_W-1:0]  total;
  logic [sem_pkg::CNT_W-1:0]  stored;
  logic [sem_pkg::CNT_W-1:0]  outlin;
  logic [sem_pkg::ROW_W-1:0]  orow;
  logic [sem_pkg::WCFG_W-1:0] ocol;
  logic [AW-1:0]              wptr;
  logic [AW-1:0]              optr;

  logic [sem_pkg::WCFG_W-1:0] new_w;
  logic [sem_pkg::HCFG_W-1:0] new_h;
  logic [23:0]                prod;
  logic                       acc;
  logic                       is_pix;
  logic                       emit;
  logic                       last;
  logic [sem_pkg::CNT_W-1:0]  diff;

  always_comb begin
    new_w = (cfg_index == sem_pkg::CFG_IMAGE_WIDTH) ? eff_w(cfg_data[sem_pkg::WCFG_W-1:0])
                                                    : w_eff;
    new_h = (cfg_index == sem_pkg::CFG_IMAGE_HEIGHT) ? eff_h(cfg_data) : h_eff;
    prod  = {13'b0, new_w} * {11'b0, new_h};
  end

  assign in_stall = q_full;
  assign acc      = in_valid && !in_stall;
  assign diff     = stored - outlin;
  assign is_pix   = (operation == sem_pkg::OP_PIXEL) && (stored < total);
  assign emit     = is_pix ? (diff >= ({12'b0, w_eff} + 23'd1))
                           : ((stored == total) && (outlin < total));
  assign last     = (outlin == total - 23'd1);

  assign wr_en    = acc && is_pix;
  assign wr_addr  = wptr;
  assign wr_data  = {red_in, green_in, blue_in};
  assign push     = acc && emit;
  assign push_ptr = optr;
  assign width    = w_eff;

  always_comb begin
    push_flags.top_ok    = (orow != '0);
    push_flags.bot_ok    = ((orow + 13'd1) != h_eff);
    push_flags.left_ok   = (ocol != '0);
    push_flags.right_ok  = ((ocol + 11'd1) != w_eff);
    push_flags.frame_end = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff  <= eff_w(sem_pkg::WIDTH_RESET);
      h_eff  <= sem_pkg::HEIGHT_RESET;
      total  <= 23'({13'b0, eff_w(sem_pkg::WIDTH_RESET)} * {11'b0, sem_pkg::HEIGHT_RESET});
      stored <= '0;
      outlin <= '0;
      orow   <= '0;
      ocol   <= '0;
      wptr   <= '0;
      optr   <= '0;
    end else if (cfg_write) begin
      w_eff  <= new_w;
      h_eff  <= new_h;
      total  <= prod[sem_pkg::CNT_W-1:0];
      stored <= '0;
      outlin <= '0;
      orow   <= '0;
      ocol   <= '0;
      optr   <= wptr;
    end else if (acc) begin
      if (is_pix) begin
        stored <= stored + 23'd1;
        wptr   <= wptr + 1'b1;
      end
      if (emit) begin
        optr <= optr + 1'b1;
        if (last) begin
          // frame done: next pixel opens a new frame
          stored <= '0;
          outlin <= '0;
          orow   <= '0;
          ocol   <= '0;
        end else begin
          outlin <= outlin + 23'd1;
          if ((ocol + 11'd1) == w_eff) begin
            ocol <= '0;
            orow <= orow + 13'd1;
          end else begin
            ocol <= ocol + 11'd1;
          end
        end
      end
    end
  end

  `SEM_ASSERT_IMP(a_out_behind_in, clk, rst, 1'b1, stored >= outlin, "output ahead of input")
  `SEM_ASSERT_IMP(a_lead_bounded, clk, rst, 1'b1, diff <= ({12'b0, w_eff} + 23'd2), "pixel lead too large")

endmodule

/* rtl/sem_queue.sv */
`include "sobel_edge_magnitude_core_assert.svh"

module sem_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         empty
);

  localparam int D  = sem_pkg::QUEUE_DEPTH;
  localparam int IW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D + 1);

  logic [W-1:0]  mem [D];
  logic [IW-1:0] rd;
  logic [IW-1:0] wr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(D));
  assign empty = (count == '0);
  assign dout  = mem[rd];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd    <= '0;
      wr    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr <= (wr == IW'(D - 1)) ? '0 : wr + 1'b1;
      end
      if (pop) begin
        rd <= (rd == IW'(D - 1)) ? '0 : rd + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SEM_ASSERT_IMP(a_no_overflow, clk, rst, push, !full || pop, "word pushed into full queue")

endmodule

/* rtl/sem_back.sv */
`include "sobel_edge_magnitude_core_assert.svh"

module sem_back #(
  parameter int AW = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [sem_pkg::WCFG_W-1:0]  width,
  input  logic                        q_empty,
  input  logic [AW-1:0]               q_ptr,
  input  sem_pkg::job_flags_t         q_flags,
  output logic                        pop,
  output logic [AW-1:0]               raddr,
  input  logic [3*sem_pkg::PIX_W-1:0] rdata,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sem_pkg::PIX_W-1:0]   red_edge,
  output logic [sem_pkg::PIX_W-1:0]   green_edge,
  output logic [sem_pkg::PIX_W-1:0]   blue_edge,
  output logic                        frame_end
);

  sem_pkg::back_state_t state, state_next;

  logic [AW-1:0]                   ptr;
  sem_pkg::job_flags_t             fl;
  logic [1:0]                      rc, cc;
  logic [3:0]                      iss;
  logic                            d_v, d_last;
  logic [1:0]                      d_r, d_c;
  logic signed [sem_pkg::ACC_W-1:0] gx [3];
  logic signed [sem_pkg::ACC_W-1:0] gy [3];
  logic signed [sem_pkg::ACC_W-1:0] tx [3];
  logic signed [sem_pkg::ACC_W-1:0] ty [3];
  logic [sem_pkg::SQ_W-1:0]        n [3];
  logic [sem_pkg::PIX_W-1:0]       s [3];
  logic [sem_pkg::PIX_W-1:0]       s_try [3];
  logic [sem_pkg::PIX_W-1:0]       res [3];
  logic [2:0]                      bitc;
  logic [AW-1:0]                   row_off, col_off, wv;
  logic                            tap_ok;
  logic                            out_free;

  assign wv       = AW'(width);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    case (rc)
      2'd0:    row_off = -wv;
      2'd2:    row_off = wv;
      default: row_off = '0;
    endcase
    case (cc)
      2'd0:    col_off = '1;
      2'd2:    col_off = AW'(1);
      default: col_off = '0;
    endcase
  end

  assign raddr  = ptr + row_off + col_off;
  assign tap_ok = (d_r != 2'd0 || fl.top_ok) && (d_r != 2'd2 || fl.bot_ok) &&
                  (d_c != 2'd0 || fl.left_ok) && (d_c != 2'd2 || fl.right_ok);

  // Sobel weights: center row/column counts twice
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [sem_pkg::PIX_W-1:0] v;
      logic signed [sem_pkg::ACC_W-1:0] v1, v2;
      v  = tap_ok ? rdata[(2-i)*sem_pkg::PIX_W +: sem_pkg::PIX_W] : '0;
      v1 = $signed({4'b0, v});
      v2 = $signed({3'b0, v, 1'b0});
      case (d_c)
        2'd0:    tx[i] = (d_r == 2'd1) ? -v2 : -v1;
        2'd2:    tx[i] = (d_r == 2'd1) ? v2 : v1;
        default: tx[i] = '0;
      endcase
      case (d_r)
        2'd0:    ty[i] = (d_c == 2'd1) ? -v2 : -v1;
        2'd2:    ty[i] = (d_c == 2'd1) ? v2 : v1;
        default: ty[i] = '0;
      endcase
      s_try[i] = s[i] | (8'd1 << bitc);
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      sem_pkg::BK_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = sem_pkg::BK_READ;
        end
      end
      sem_pkg::BK_READ: begin
        if (d_v && d_last) state_next = sem_pkg::BK_SQUARE;
      end
      sem_pkg::BK_SQUARE: state_next = sem_pkg::BK_ROOT;
      sem_pkg::BK_ROOT: begin
        if (bitc == 3'd0) state_next = sem_pkg::BK_ROUND;
      end
      sem_pkg::BK_ROUND: state_next = sem_pkg::BK_DONE;
      sem_pkg::BK_DONE: begin
        if (out_free) state_next = sem_pkg::BK_IDLE;
      end
      default: state_next = sem_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sem_pkg::BK_IDLE;
      out_valid <= 1'b0;
      d_v       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == sem_pkg::BK_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      d_v <= (state == sem_pkg::BK_READ) && (iss < 4'd9);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      sem_pkg::BK_IDLE: begin
        ptr <= q_ptr;
        fl  <= q_flags;
        rc  <= '0;
        cc  <= '0;
        iss <= '0;
        for (int i = 0; i < 3; i++) begin
          gx[i] <= '0;
          gy[i] <= '0;
        end
      end
      sem_pkg::BK_READ: begin
        if (iss < 4'd9) begin
          d_r    <= rc;
          d_c    <= cc;
          d_last <= (iss == 4'd8);
          iss    <= iss + 4'd1;
          if (cc == 2'd2) begin
            cc <= '0;
            rc <= rc + 2'd1;
          end else begin
            cc <= cc + 2'd1;
          end
        end
        if (d_v) begin
          for (int i = 0; i < 3; i++) begin
            gx[i] <= gx[i] + tx[i];
            gy[i] <= gy[i] + ty[i];
          end
        end
      end
      sem_pkg::BK_SQUARE: begin
        for (int i = 0; i < 3; i++) begin
          n[i] <= sem_pkg::SQ_W'(gx[i] * gx[i]) + sem_pkg::SQ_W'(gy[i] * gy[i]);
          s[i] <= '0;
        end
        bitc <= 3'd7;
      end
      sem_pkg::BK_ROOT: begin
        // one result bit per cycle, all channels side by side
        for (int i = 0; i < 3; i++) begin
          if ({5'b0, 16'(s_try[i] * s_try[i])} <= n[i]) s[i] <= s_try[i];
        end
        bitc <= bitc - 3'd1;
      end
      sem_pkg::BK_ROUND: begin
        for (int i = 0; i < 3; i++) begin
          if (n[i] >= sem_pkg::SQ_CLAMP) begin
            res[i] <= sem_pkg::EDGE_MAX;
          end else if (n[i] > {5'b0, (16'(s[i] * s[i]) + {8'b0, s[i]})}) begin
            res[i] <= s[i] + 8'd1;
          end else begin
            res[i] <= s[i];
          end
        end
      end
      sem_pkg::BK_DONE: begin
        if (out_free) begin
          red_edge   <= res[0];
          green_edge <= res[1];
          blue_edge  <= res[2];
          frame_end  <= fl.frame_end;
        end
      end
      default: ;
    endcase
  end

  `SEM_ASSERT_IMP(a_load_from_done, clk, rst, $rose(out_valid), $past(state) == sem_pkg::BK_DONE, "result shown without finished job")
  `SEM_ASSERT_NXT(a_pop_starts_read, clk, rst, pop, state == sem_pkg::BK_READ && iss == 4'd0, "job not read from first tap")

endmodule

/* rtl/sobel_edge_magnitude_core.sv */
// 3x3 Sobel edge magnitude over RGB pixels in raster order.
// Input channel: in_valid/in_stall with operation, red_in, green_in, blue_in.
//   operation 0 stores a pixel, 1 is a flush word that drives out one
//   pending result after the frame's last pixel.
// Output channel: out_valid/out_stall with red_edge, green_edge, blue_edge
//   and frame_end, which marks the result of the frame's last pixel.
// Config: cfg_write with cfg_index 0 = image width, 1 = image height;
//   a write restarts the frame. Write only while the block is idle.
// Results trail the pixels by width+1 words. Each result in the back end
// takes nine reads of the single-read-port line store and an 8-step square
// root. A two-word job queue lets the front keep taking words meanwhile;
// when it fills, in_stall rises.
// Reset: 640x480 frame, front counters and the job queue cleared; the line
// store holds no defined data until written.
// While out_stall is high the finished result holds on the output register
// and the back end waits with the next result.
module sobel_edge_magnitude_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [0:0]                 cfg_index,
  input  logic [sem_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       operation,
  input  logic [sem_pkg::PIX_W-1:0]  red_in,
  input  logic [sem_pkg::PIX_W-1:0]  green_in,
  input  logic [sem_pkg::PIX_W-1:0]  blue_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sem_pkg::PIX_W-1:0]  red_edge,
  output logic [sem_pkg::PIX_W-1:0]  green_edge,
  output logic [sem_pkg::PIX_W-1:0]  blue_edge,
  output logic                       frame_end
);

  // room for two rows, the window, and the queued lead
  localparam int DEPTH = 1 << $clog2(2 * MAX_WIDTH + 8);
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = $bits(sem_pkg::job_flags_t);
  localparam int PW    = 3 * sem_pkg::PIX_W;

  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [PW-1:0]              wr_data;
  logic [AW-1:0]              raddr;
  logic [PW-1:0]              rdata;
  logic                       push, pop, q_full, q_empty;
  logic [AW-1:0]              push_ptr;
  sem_pkg::job_flags_t        push_flags;
  logic [AW+FW-1:0]           q_dout;
  logic [sem_pkg::WCFG_W-1:0] width;

  sem_front #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_front (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .operation, .red_in, .green_in, .blue_in,
    .wr_en, .wr_addr, .wr_data,
    .push, .push_ptr, .push_flags, .q_full, .width
  );

  sem_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_store (
    .clk, .we(wr_en), .waddr(wr_addr), .wdata(wr_data), .raddr, .rdata
  );

  sem_queue #(.W(AW + FW)) u_queue (
    .clk, .rst, .push, .din({push_ptr, push_flags}), .pop,
    .dout(q_dout), .full(q_full), .empty(q_empty)
  );

  sem_back #(.AW(AW)) u_back (
    .clk, .rst, .width, .q_empty,
    .q_ptr(q_dout[AW+FW-1:FW]), .q_flags(sem_pkg::job_flags_t'(q_dout[FW-1:0])),
    .pop, .raddr, .rdata,
    .out_valid, .out_stall, .red_edge, .green_edge, .blue_edge, .frame_end
  );

endmodule
